>>> rtl/sqlpow_pkg.sv
// Shared types and constants for the checked integer power/mod/div/abs unit.
`default_nettype none
package sqlpow_pkg;
	localparam int unsigned DW = 64;
	localparam logic [DW-1:0] INT_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] INT_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] ONE     = {{(DW-1){1'b0}}, 1'b1};

	typedef enum logic [1:0] {
		OP_POW = 2'd0,
		OP_MOD = 2'd1,
		OP_DIV = 2'd2,
		OP_ABS = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_RANGE = 2'd1,
		ERR_DIVZ  = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POW_STEP,
		ST_POW_MUL,
		ST_POW_SHIFT,
		ST_POW_SQR,
		ST_DIV,
		ST_WB
	} state_t;

	// Result of the iterative multiplier, full 128-bit product.
	typedef struct packed {
		logic              done;
		logic [2*DW-1:0]   prod;
	} mul_rsp_t;

	// Result of the iterative divider.
	typedef struct packed {
		logic              done;
		logic [DW-1:0]     quo;
		logic [DW-1:0]     rem;
	} div_rsp_t;
endpackage
`default_nettype wire

>>> rtl/sqlpow_in_if.sv
// Input channel: operation and two signed 64-bit operands.
`default_nettype none
interface sqlpow_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic signed [63:0] left_operand;
	logic signed [63:0] right_operand;
	modport source (output valid, output op, output left_operand, output right_operand,
		input ready);
	modport sink (input valid, input op, input left_operand, input right_operand,
		output ready);
endinterface
`default_nettype wire

>>> rtl/sqlpow_out_if.sv
// Output channel: signed 64-bit value and error code.
`default_nettype none
interface sqlpow_out_if;
	logic        valid;
	logic        ready;
	logic signed [63:0] value;
	logic [1:0]  error_code;
	modport source (output valid, output value, output error_code, input ready);
	modport sink (input valid, input value, input error_code, output ready);
endinterface
`default_nettype wire

>>> rtl/sqlpow_mul.sv
// Iterative 64x64 unsigned multiplier: four 32x32 partial products, accumulated one at a time.
`default_nettype none
module sqlpow_mul
	import sqlpow_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] a,
	input  wire logic [DW-1:0] b,
	output mul_rsp_t           rsp
);
	localparam int unsigned HW = DW / 2;

	logic [DW-1:0]   a_q, b_q;
	logic [DW-1:0]   pp_q;
	logic [2*DW-1:0] acc_q;
	logic [2:0]      cnt_q;
	logic            busy_q, done_q;
	logic [HW-1:0]   ah, bh;
	logic [2*DW-1:0] pp_sh;

	// Operand half selection for the current partial product
	always_comb begin
		ah = cnt_q[1] ? a_q[DW-1:HW] : a_q[HW-1:0];
		bh = cnt_q[0] ? b_q[DW-1:HW] : b_q[HW-1:0];
	end

	// Alignment of the previous partial product (index cnt_q - 1)
	always_comb begin
		case (cnt_q)
			3'd1:    pp_sh = {{DW{1'b0}}, pp_q};
			3'd2,
			3'd3:    pp_sh = {{HW{1'b0}}, pp_q, {HW{1'b0}}};
			3'd4:    pp_sh = {pp_q, {DW{1'b0}}};
			default: pp_sh = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: multiply one cycle, accumulate the next
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			pp_q  <= {{HW{1'b0}}, ah} * {{HW{1'b0}}, bh};
			acc_q <= acc_q + pp_sh;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;
endmodule
`default_nettype wire

>>> rtl/sqlpow_div.sv
// Restoring unsigned 64-bit divider, one quotient bit per cycle.
`default_nettype none
module sqlpow_div
	import sqlpow_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output div_rsp_t           rsp
);
	localparam int unsigned CW = $clog2(DW);

	logic [DW-1:0] q_q, r_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   shifted, trial;

	// Shift in next dividend bit and trial subtract
	always_comb begin
		shifted = {r_q, q_q[DW-1]};
		trial   = shifted - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				r_q <= trial[DW-1:0];
				q_q <= {q_q[DW-2:0], 1'b1};
			end else begin
				r_q <= shifted[DW-1:0];
				q_q <= {q_q[DW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = q_q;
	assign rsp.rem  = r_q;
endmodule
`default_nettype wire

>>> rtl/sql_integer_pow_mod_div_abs_unit.sv
// Top level: sequencer for checked power, modulo, divide and absolute value.
//
// channel  | dir | payload
// in_ch    | in  | op, left_operand, right_operand
// out_ch   | out | value, error_code
//
// Absolute value and early errors go from decode straight to writeback.
// Modulo and divide wait on the 64-step restoring divider.
// Power works through the exponent bit by bit: a multiply for each set bit
// and a squaring while exponent bits remain, for up to 63 exponent bits.
// One item at a time; in_ch.ready is high only when the sequencer is idle.
// The result register holds until taken; a new item is accepted meanwhile.
`default_nettype none
module sql_integer_pow_mod_div_abs_unit
	import sqlpow_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	sqlpow_in_if.sink    in_ch,
	sqlpow_out_if.source out_ch
);
	state_t        state_q, state_d;
	op_t           op_q;
	logic [DW-1:0] a_q, b_q, e_q;
	logic [DW-1:0] res_mag_q, cur_mag_q;
	logic          res_neg_q, cur_neg_q, sign_q;
	logic [DW-1:0] fin_val_q;
	err_t          fin_err_q;
	logic          out_valid_q;
	logic [DW-1:0] out_val_q;
	err_t          out_err_q;

	logic          mul_start, div_start;
	logic [DW-1:0] mul_a, mul_b;
	mul_rsp_t      mul_rsp;
	div_rsp_t      div_rsp;

	logic          accept, wb_go;
	logic [DW-1:0] a_mag, b_mag, e_next, mul_limit, div_pick;
	logic          prod_neg, mul_fits, sqr_fits, a_neg, b_neg;
	logic          pow_trivial, div_trivial;

	// Operand decode
	always_comb begin
		a_neg     = a_q[DW-1];
		b_neg     = b_q[DW-1];
		a_mag     = a_neg ? (~a_q + ONE) : a_q;
		b_mag     = b_neg ? (~b_q + ONE) : b_q;
		e_next    = {1'b0, e_q[DW-1:1]};
		prod_neg  = res_neg_q ^ cur_neg_q;
		mul_limit = prod_neg ? INT_MIN : INT_MAX;
		mul_fits  = (mul_rsp.prod[2*DW-1:DW] == '0) && (mul_rsp.prod[DW-1:0] <= mul_limit);
		sqr_fits  = (mul_rsp.prod[2*DW-1:DW] == '0) && (mul_rsp.prod[DW-1:0] <= INT_MAX);
		pow_trivial = (b_q == '0) || b_neg;
		div_trivial = (b_q == '0) || ((op_q == OP_DIV) && (a_q == INT_MIN) && (b_q == '1));
		div_pick    = (op_q == OP_MOD) ? div_rsp.rem : div_rsp.quo;
		accept      = in_ch.valid && in_ch.ready;
		wb_go       = !out_valid_q || out_ch.ready;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (accept) state_d = ST_DECODE;
			ST_DECODE: begin
				case (op_q)
					OP_POW:  state_d = pow_trivial ? ST_WB : ST_POW_STEP;
					OP_MOD,
					OP_DIV:  state_d = div_trivial ? ST_WB : ST_DIV;
					default: state_d = ST_WB;
				endcase
			end
			ST_POW_STEP:  state_d = e_q[0] ? ST_POW_MUL : ST_POW_SHIFT;
			ST_POW_MUL: begin
				if (mul_rsp.done) state_d = mul_fits ? ST_POW_SHIFT : ST_WB;
			end
			ST_POW_SHIFT: state_d = (e_next != '0) ? ST_POW_SQR : ST_WB;
			ST_POW_SQR: begin
				if (mul_rsp.done) state_d = sqr_fits ? ST_POW_STEP : ST_WB;
			end
			ST_DIV:       if (div_rsp.done) state_d = ST_WB;
			ST_WB:        if (wb_go) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		mul_start   = 1'b0;
		div_start   = 1'b0;
		mul_a       = cur_mag_q;
		mul_b       = cur_mag_q;
		case (state_q)
			ST_POW_STEP: begin
				mul_start = e_q[0];
				mul_a     = res_mag_q;
			end
			ST_POW_SHIFT: mul_start = (e_next != '0);
			ST_DECODE:    div_start = (op_q inside {OP_MOD, OP_DIV}) && !div_trivial;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WB && wb_go) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q <= op_t'(in_ch.op);
					a_q  <= in_ch.left_operand;
					b_q  <= in_ch.right_operand;
				end
			end
			ST_DECODE: begin
				fin_err_q <= ERR_NONE;
				fin_val_q <= '0;
				res_mag_q <= ONE;
				res_neg_q <= 1'b0;
				cur_mag_q <= a_mag;
				cur_neg_q <= a_neg;
				e_q       <= b_q;
				sign_q    <= (op_q == OP_MOD) ? a_neg : (a_neg ^ b_neg);
				case (op_q)
					OP_POW: begin
						if (b_q == '0 && a_q == '0) fin_err_q <= ERR_RANGE;
						else fin_val_q <= ONE;
					end
					OP_MOD,
					OP_DIV: begin
						if (b_q == '0) fin_err_q <= ERR_DIVZ;
						else if (div_trivial) fin_err_q <= ERR_RANGE;
					end
					default: begin
						if (a_q == INT_MIN) fin_err_q <= ERR_RANGE;
						else fin_val_q <= a_mag;
					end
				endcase
			end
			ST_POW_MUL: begin
				if (mul_rsp.done) begin
					if (mul_fits) begin
						res_mag_q <= mul_rsp.prod[DW-1:0];
						res_neg_q <= prod_neg && (mul_rsp.prod[DW-1:0] != '0);
					end else begin
						fin_err_q <= ERR_RANGE;
						fin_val_q <= '0;
					end
				end
			end
			ST_POW_SHIFT: begin
				e_q       <= e_next;
				fin_val_q <= res_neg_q ? (~res_mag_q + ONE) : res_mag_q;
			end
			ST_POW_SQR: begin
				if (mul_rsp.done) begin
					if (sqr_fits) begin
						cur_mag_q <= mul_rsp.prod[DW-1:0];
						cur_neg_q <= 1'b0;
					end else begin
						fin_err_q <= ERR_RANGE;
						fin_val_q <= '0;
					end
				end
			end
			ST_DIV: begin
				if (div_rsp.done) fin_val_q <= sign_q ? (~div_pick + ONE) : div_pick;
			end
			ST_WB: begin
				if (wb_go) begin
					out_val_q <= fin_val_q;
					out_err_q <= fin_err_q;
				end
			end
			default: ;
		endcase
	end

	sqlpow_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.rsp    (mul_rsp)
	);

	sqlpow_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_mag),
		.divisor  (b_mag),
		.rsp      (div_rsp)
	);

	assign out_ch.valid      = out_valid_q;
	assign out_ch.value      = out_val_q;
	assign out_ch.error_code = out_err_q;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_err_q != ERR_NONE) |-> (out_val_q == '0))
		else $error("error result with nonzero value");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ch.ready)
		else $error("ready after accept");
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_POW_MUL || state_q == ST_POW_SQR))
		else $error("multiply done outside power step");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divide done outside divide state");
`endif
endmodule
`default_nettype wire
